[hw/rtl/cfct_pkg.sv]
`default_nettype none

package cfct_pkg;

  // Frame layout
  localparam int unsigned FrameLength  = 22;
  localparam int unsigned TagPosition  = 15;
  localparam int unsigned ChannelCount = 2;
  localparam int unsigned ChanW        = 1;
  localparam int unsigned PosW         = 5;
  localparam int unsigned ByteW        = 8;

  // Card ID table, code = table slot + 1
  localparam int unsigned IdCount = 10;
  localparam int unsigned CodeW   = 4;
  localparam logic [ByteW-1:0] CardIds [IdCount] = '{
    8'h11, 8'h12, 8'h13, 8'h14, 8'h21, 8'h22, 8'h23, 8'h31, 8'h32, 8'h33
  };

  // Configuration register map
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHeaderFirst  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeaderSecond = 1'b1;
  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'h04;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h16;

  // Outcome of one byte passed from frame check to tag latch
  typedef struct packed {
    logic             done;
    logic             good;
    logic [ByteW-1:0] tag;
  } frame_res_t;

endpackage

`default_nettype wire

[hw/rtl/card_frame_check_and_tag_latch_top.sv]
// Card frame check and tag latch.
// Input channel (in_valid_i / in_stall_o) carries one received byte per item
// with its reader channel number and an idle flag. Each item gives exactly one
// result item on the output channel (out_valid_o / out_stall_i): the current
// drive code and flags telling whether the byte closed a frame, whether the
// frame was good, and whether a new card tag was recorded.
// Items pass an input register and a result register: a result is shown once its
// item has moved on into the result register and can be taken at the next edge, and one
// item is taken every cycle while the receiver keeps out_stall_i low.
// Per-channel frame state and the tag latch are read and updated in the
// single stage between the two registers, so back-to-back bytes of one
// channel need no bubble.
// When the receiver stalls, the result register holds; the input register
// then fills and in_stall_o rises until the result is taken.
// The header registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// write them only while no item is in flight (the block does not enforce this).
// Reset clears both registers' valid flags, all channel counts and checksums,
// the seen-card mask and the drive code, and loads the header defaults.
`default_nettype none

module card_frame_check_and_tag_latch_top
  import cfct_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ChanW-1:0]   channel_i,
  input  wire logic [ByteW-1:0]   data_byte_i,
  input  wire logic               frame_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CodeW-1:0]        drive_code_o,
  output logic                    frame_done_o,
  output logic                    frame_good_o,
  output logic                    new_tag_o
);

  logic [ByteW-1:0] hdr_first_q;
  logic [ByteW-1:0] hdr_second_q;

  logic             in_valid_q;
  logic [ChanW-1:0] in_chan_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_end_q;

  logic             out_valid_q;
  logic [CodeW-1:0] out_code_q;
  logic             out_done_q;
  logic             out_good_q;
  logic             out_new_q;

  logic             advance;
  logic             step;
  logic             in_take;
  frame_res_t       frame_res;
  logic [CodeW-1:0] code;
  logic             fresh;

  // Pipeline moves when the result register is free or being emptied
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Hold the header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHeaderFirst:  hdr_first_q  <= cfg_data_i;
        CfgHeaderSecond: hdr_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_chan_q <= channel_i;
      in_byte_q <= data_byte_i;
      in_end_q  <= frame_end_i;
    end
  end

  cfct_frame_check u_frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .channel_i       (in_chan_q),
    .data_byte_i     (in_byte_q),
    .frame_end_i     (in_end_q),
    .header_first_i  (hdr_first_q),
    .header_second_i (hdr_second_q),
    .res_o           (frame_res)
  );

  cfct_tag_latch u_tag_latch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .res_i     (frame_res),
    .code_o    (code),
    .new_tag_o (fresh)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_code_q <= code;
      out_done_q <= frame_res.done;
      out_good_q <= frame_res.good;
      out_new_q  <= fresh;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign drive_code_o = out_code_q;
  assign frame_done_o = out_done_q;
  assign frame_good_o = out_good_q;
  assign new_tag_o    = out_new_q;

endmodule

`default_nettype wire

[hw/rtl/cfct_frame_check.sv]
`default_nettype none

module cfct_frame_check
  import cfct_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [ChanW-1:0] channel_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  input  wire logic             frame_end_i,
  input  wire logic [ByteW-1:0] header_first_i,
  input  wire logic [ByteW-1:0] header_second_i,
  output frame_res_t            res_o
);

  logic [PosW-1:0]  pos_q [ChannelCount];
  logic [ByteW-1:0] xor_q [ChannelCount];
  logic             hdr_q [ChannelCount];
  logic [ByteW-1:0] tag_q [ChannelCount];

  logic [PosW-1:0]  pos_d;
  logic [ByteW-1:0] xor_d;
  logic             hdr_d;
  logic [ByteW-1:0] tag_d;
  logic             done;
  logic             good;

  // Check the byte against the selected channel's frame state
  always_comb begin
    pos_d = pos_q[channel_i];
    xor_d = xor_q[channel_i];
    hdr_d = hdr_q[channel_i];
    tag_d = tag_q[channel_i];
    done  = 1'b0;
    good  = 1'b0;
    if (pos_q[channel_i] >= PosW'(FrameLength - 1)) begin
      done = 1'b1;
      good = hdr_q[channel_i] && ((~xor_q[channel_i]) == data_byte_i);
    end else begin
      xor_d = xor_q[channel_i] ^ data_byte_i;
      if (pos_q[channel_i] == PosW'(0) && data_byte_i != header_first_i) begin
        hdr_d = 1'b0;
      end
      if (pos_q[channel_i] == PosW'(1) && data_byte_i != header_second_i) begin
        hdr_d = 1'b0;
      end
      if (pos_q[channel_i] == PosW'(TagPosition)) begin
        tag_d = data_byte_i;
      end
      pos_d = pos_q[channel_i] + PosW'(1);
      done  = frame_end_i;
    end
    // Closing a frame restarts the channel
    if (done) begin
      pos_d = '0;
      xor_d = '0;
      hdr_d = 1'b1;
      tag_d = '0;
    end
  end

  assign res_o.done = done;
  assign res_o.good = good;
  assign res_o.tag  = tag_q[channel_i];

  // Advance the channel state on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < ChannelCount; c++) begin
        pos_q[c] <= '0;
        xor_q[c] <= '0;
        hdr_q[c] <= 1'b1;
        tag_q[c] <= '0;
      end
    end else if (step_i) begin
      pos_q[channel_i] <= pos_d;
      xor_q[channel_i] <= xor_d;
      hdr_q[channel_i] <= hdr_d;
      tag_q[channel_i] <= tag_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cfct_tag_latch.sv]
`default_nettype none

module cfct_tag_latch
  import cfct_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire frame_res_t       res_i,
  output logic [CodeW-1:0]      code_o,
  output logic                  new_tag_o
);

  logic [IdCount-1:0] seen_q;
  logic [IdCount-1:0] seen_d;
  logic [CodeW-1:0]   code_q;
  logic [CodeW-1:0]   code_d;
  logic [IdCount-1:0] hit;
  logic [CodeW-1:0]   hit_code;
  logic               fresh;

  // Look up the tag in the card table
  always_comb begin
    hit      = '0;
    hit_code = '0;
    for (int i = 0; i < IdCount; i++) begin
      if (res_i.tag == CardIds[i]) begin
        hit[i]   = 1'b1;
        hit_code = CodeW'(i + 1);
      end
    end
  end

  // Record an unseen card from a good frame
  always_comb begin
    fresh  = res_i.done && res_i.good && (|(hit & ~seen_q));
    seen_d = seen_q;
    code_d = code_q;
    if (fresh) begin
      seen_d = seen_q | hit;
      code_d = hit_code;
    end
  end

  assign code_o    = code_d;
  assign new_tag_o = fresh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      code_q <= '0;
    end else if (step_i) begin
      seen_q <= seen_d;
      code_q <= code_d;
    end
  end

endmodule

`default_nettype wire

[bench/card_frame_check_and_tag_latch_checker.sv]
`timescale 1ns / 1ps

module card_frame_check_and_tag_latch_checker
  import cfct_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [ChanW-1:0]   channel_i,
  input  wire logic [ByteW-1:0]   data_byte_i,
  input  wire logic               frame_end_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [CodeW-1:0]   drive_code_i,
  input  wire logic               frame_done_i,
  input  wire logic               frame_good_i,
  input  wire logic               new_tag_i,
  output int                      errors_o,
  output int                      pending_o
);

  localparam int unsigned KnownCount = 10;
  localparam logic [ByteW-1:0] KnownCards [KnownCount] = '{
    8'h11, 8'h12, 8'h13, 8'h14, 8'h21, 8'h22, 8'h23, 8'h31, 8'h32, 8'h33
  };

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             done;
    logic             good;
    logic             fresh;
  } card_outcome_t;

  // Mirror of the header registers and the per-channel frame state
  logic [ByteW-1:0]      hdr_first;
  logic [ByteW-1:0]      hdr_second;
  logic [PosW-1:0]       byte_cnt   [ChannelCount];
  logic [ByteW-1:0]      xor_acc    [ChannelCount];
  logic                  hdr_ok     [ChannelCount];
  logic [ByteW-1:0]      tag_byte   [ChannelCount];
  logic [KnownCount-1:0] cards_seen;
  logic [CodeW-1:0]      drive_code;

  card_outcome_t outcome_q [$];
  int            mismatches;

  // Advance one channel by one byte and return the outcome it shows
  function automatic card_outcome_t check_and_latch(input logic [ChanW-1:0] ch,
                                                    input logic [ByteW-1:0] b,
                                                    input logic             idle);
    card_outcome_t res;
    int            pos;
    logic          hit;
    res = '0;
    hit = 1'b0;
    if (int'(ch) < ChannelCount) begin
      pos = int'(byte_cnt[ch]);
      if (pos >= FrameLength - 1) begin
        // Check byte: inverted XOR of everything before it
        res.done = 1'b1;
        res.good = hdr_ok[ch] && (~xor_acc[ch] == b);
      end else begin
        xor_acc[ch] = xor_acc[ch] ^ b;
        if (pos == 0 && b != hdr_first) hdr_ok[ch] = 1'b0;
        if (pos == 1 && b != hdr_second) hdr_ok[ch] = 1'b0;
        if (pos == TagPosition) tag_byte[ch] = b;
        byte_cnt[ch] = byte_cnt[ch] + 1'b1;
        if (idle) res.done = 1'b1;
      end
      if (res.done) begin
        // Latch a known card only the first time it shows up
        if (res.good) begin
          for (int i = 0; i < KnownCount; i++) begin
            if (!hit && KnownCards[i] == tag_byte[ch]) begin
              hit = 1'b1;
              if (!cards_seen[i]) begin
                cards_seen[i] = 1'b1;
                drive_code    = CodeW'(i + 1);
                res.fresh     = 1'b1;
              end
            end
          end
        end
        byte_cnt[ch] = '0;
        xor_acc[ch]  = '0;
        hdr_ok[ch]   = 1'b1;
        tag_byte[ch] = '0;
      end
    end
    res.code = drive_code;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    card_outcome_t want;
    if (!rst_ni) begin
      hdr_first  = HeaderFirstRst;
      hdr_second = HeaderSecondRst;
      for (int c = 0; c < ChannelCount; c++) begin
        byte_cnt[c] = '0;
        xor_acc[c]  = '0;
        hdr_ok[c]   = 1'b1;
        tag_byte[c] = '0;
      end
      cards_seen = '0;
      drive_code = '0;
      mismatches = 0;
      outcome_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgHeaderFirst) hdr_first = cfg_data_i;
        if (cfg_idx_i == CfgHeaderSecond) hdr_second = cfg_data_i;
      end
      // Compare a taken result with the oldest outcome
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $error("result item with no item pending");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (drive_code_i !== want.code) begin
            $error("drive_code: expected %0d, actual %0d", want.code, drive_code_i);
            mismatches++;
          end
          if (frame_done_i !== want.done) begin
            $error("frame_done: expected %0d, actual %0d", want.done, frame_done_i);
            mismatches++;
          end
          if (frame_good_i !== want.good) begin
            $error("frame_good: expected %0d, actual %0d", want.good, frame_good_i);
            mismatches++;
          end
          if (new_tag_i !== want.fresh) begin
            $error("new_tag: expected %0d, actual %0d", want.fresh, new_tag_i);
            mismatches++;
          end
        end
      end
      // Predict each accepted item
      if (in_valid_i && !in_stall_i) begin
        outcome_q.push_back(check_and_latch(channel_i, data_byte_i, frame_end_i));
      end
      errors_o  <= mismatches;
      pending_o <= outcome_q.size();
    end
  end

endmodule

[bench/card_frame_check_and_tag_latch_top_tb.sv]
`timescale 1ns / 1ps

module card_frame_check_and_tag_latch_top_tb;
  import cfct_pkg::*;

  localparam int IdlePct      = 7;
  localparam int HoldCycles   = 80;
  localparam int WatchLimit   = 1000;
  localparam int PhaseItems   = 250;
  localparam int PhaseCount   = 4;
  localparam int SettleCycles = 10;
  localparam int MaxFrame     = 32;

  typedef enum int {FrmGood, FrmBadSum, FrmBadHead, FrmShort, FrmNoise} frame_kind_e;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx    = '0;
  logic [ByteW-1:0]   cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic [ChanW-1:0]   channel    = '0;
  logic [ByteW-1:0]   data_byte  = '0;
  logic               frame_end  = 1'b0;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [CodeW-1:0]   drive_code;
  logic               frame_done;
  logic               frame_good;
  logic               new_tag;

  logic hold_go = 1'b0;
  logic quiet   = 1'b0;
  int   errors;
  int   pending;
  int   idle_cycles = 0;

  // Stimulus copy of the headers, used to build well-formed frames
  logic [ByteW-1:0] head_first  = HeaderFirstRst;
  logic [ByteW-1:0] head_second = HeaderSecondRst;

  // One frame under way per channel
  logic [ByteW-1:0] frame_bytes [ChannelCount][MaxFrame];
  logic             frame_ends  [ChannelCount][MaxFrame];
  int               frame_len   [ChannelCount];
  int               frame_idx   [ChannelCount];

  card_frame_check_and_tag_latch_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .channel_i    (channel),
    .data_byte_i  (data_byte),
    .frame_end_i  (frame_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .drive_code_o (drive_code),
    .frame_done_o (frame_done),
    .frame_good_o (frame_good),
    .new_tag_o    (new_tag)
  );

  card_frame_check_and_tag_latch_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .channel_i    (channel),
    .data_byte_i  (data_byte),
    .frame_end_i  (frame_end),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .drive_code_i (drive_code),
    .frame_done_i (frame_done),
    .frame_good_i (frame_good),
    .new_tag_i    (new_tag),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: random stalls, one long hold-off, none while quiet
  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_go && held < HoldCycles) begin
        out_stall <= 1'b1;
        held++;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IdlePct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one item and hold it until taken
  task automatic send_item(input logic [ChanW-1:0] ch, input logic [ByteW-1:0] b,
                           input logic fe);
    logic stalled;
    if (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    channel   <= ch;
    data_byte <= b;
    frame_end <= fe;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Wait until every result has been taken
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_headers(input logic [ByteW-1:0] first_v,
                               input logic [ByteW-1:0] second_v);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgHeaderFirst;
    cfg_data <= first_v;
    @(posedge clk);
    cfg_idx  <= CfgHeaderSecond;
    cfg_data <= second_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    head_first  = first_v;
    head_second = second_v;
  endtask

  // Lay out the next frame of one channel
  task automatic build_frame(input int ch, input frame_kind_e kind,
                             input logic [ByteW-1:0] tag);
    logic [ByteW-1:0] sum;
    int               n;
    sum = '0;
    n   = FrameLength;
    if (kind == FrmShort) n = $urandom_range(1, FrameLength - 1);
    if (kind == FrmNoise) n = $urandom_range(1, 28);
    for (int i = 0; i < n; i++) begin
      frame_bytes[ch][i] = ByteW'($urandom_range(255));
      frame_ends[ch][i]  = (kind == FrmNoise) && ($urandom_range(7) == 0);
    end
    if (kind != FrmNoise) begin
      frame_bytes[ch][0] = head_first;
      if (n > 1) frame_bytes[ch][1] = head_second;
      if (n > TagPosition) frame_bytes[ch][TagPosition] = tag;
    end
    if (kind == FrmBadHead) begin
      frame_bytes[ch][$urandom_range(1)] ^= ByteW'($urandom_range(1, 255));
    end
    if (n == FrameLength && kind != FrmNoise) begin
      for (int i = 0; i < FrameLength - 1; i++) sum ^= frame_bytes[ch][i];
      frame_bytes[ch][FrameLength-1] = ~sum;
      if (kind == FrmBadSum) frame_bytes[ch][FrameLength-1] ^= ByteW'($urandom_range(1, 255));
      frame_ends[ch][FrameLength-1] = 1'($urandom_range(1));
    end else begin
      frame_ends[ch][n-1] = 1'b1;
    end
    frame_len[ch] = n;
    frame_idx[ch] = 0;
  endtask

  // Send the next byte of a channel, starting a random frame when needed
  task automatic send_next(input int ch);
    frame_kind_e      kind;
    logic [ByteW-1:0] tag;
    int               roll;
    if (frame_idx[ch] >= frame_len[ch]) begin
      roll = $urandom_range(99);
      if (roll < 60) kind = FrmGood;
      else if (roll < 70) kind = FrmBadSum;
      else if (roll < 80) kind = FrmBadHead;
      else if (roll < 90) kind = FrmShort;
      else kind = FrmNoise;
      if ($urandom_range(9) < 7) tag = CardIds[$urandom_range(IdCount - 1)];
      else tag = ByteW'($urandom_range(255));
      build_frame(ch, kind, tag);
    end
    send_item(ChanW'(ch), frame_bytes[ch][frame_idx[ch]], frame_ends[ch][frame_idx[ch]]);
    frame_idx[ch]++;
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] first_v;
    logic [ByteW-1:0] second_v;
    for (int c = 0; c < ChannelCount; c++) begin
      frame_len[c] = 0;
      frame_idx[c] = 0;
    end
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Directed: byte extremes in a short frame, then a good frame at reset headers
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b1);
    build_frame(0, FrmGood, 8'h11);
    repeat (FrameLength) send_next(0);
    in_valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own header setting
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          first_v  = 8'h00;
          second_v = 8'hFF;
        end
        1: begin
          first_v  = 8'hFF;
          second_v = 8'h00;
        end
        2: begin
          first_v  = ByteW'($urandom_range(255));
          second_v = ByteW'($urandom_range(255));
        end
        default: begin
          first_v  = HeaderFirstRst;
          second_v = HeaderSecondRst;
        end
      endcase
      write_headers(first_v, second_v);
      for (int k = 0; k < PhaseItems; k++) begin
        if (phase == 1 && k == 50) hold_go <= 1'b1;
        quiet <= (phase == 2 && k < 150);
        send_next($urandom_range(ChannelCount - 1));
      end
      in_valid <= 1'b0;
      quiet    <= 1'b0;
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/cfct_pkg.sv
hw/rtl/cfct_frame_check.sv
hw/rtl/cfct_tag_latch.sv
hw/rtl/card_frame_check_and_tag_latch_top.sv
bench/card_frame_check_and_tag_latch_checker.sv
bench/card_frame_check_and_tag_latch_top_tb.sv
